>>> hdl/jsu_pkg.sv
// Shared types, character codes and helper functions for the JSON string unescaper.
// Used by jsu_decode, jsu_outbuf and json_string_unescape_utf8; depends on nothing.
package jsu_pkg;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] HI_SURR_LO = 16'hd800;
    localparam logic [15:0] HI_SURR_HI = 16'hdbff;
    localparam logic [15:0] LO_SURR_LO = 16'hdc00;
    localparam logic [15:0] LO_SURR_HI = 16'hdfff;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'd0,
        MODE_STR  = 4'd1,
        MODE_ESC  = 4'd2,
        MODE_HEX1 = 4'd3,
        MODE_BSL  = 4'd4,
        MODE_U    = 4'd5,
        MODE_HEX2 = 4'd6
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_req;
        logic       end_of_text;
    } t_item;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [1:0]      status;
        logic [3:0][7:0] bytes;
    } t_group;

    // Bit 4 flags a byte that is not a hex digit; bits 3:0 hold the digit value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b0, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_group utf8_encode(input logic [20:0] cp);
        t_group g;
        g.status = ST_DATA;
        g.bytes  = '0;
        if (cp <= 21'h7f) begin
            g.cnt      = 3'd1;
            g.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7ff) begin
            g.cnt      = 3'd2;
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
            g.cnt      = 3'd3;
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            g.cnt      = 3'd4;
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

endpackage

>>> hdl/jsu_decode.sv
// Scanner state and the single-pass decode of one registered input byte into a result group.
// Depends on jsu_pkg.
module jsu_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  jsu_pkg::t_item i_item,
    output jsu_pkg::t_group o_group
);

    jsu_pkg::t_mode r_mode, n_mode;
    logic [1:0]     r_hex_cnt, n_hex_cnt;
    logic [15:0]    r_first, n_first;
    logic [15:0]    r_second, n_second;

    always_comb begin
        logic [7:0]     b;
        logic [4:0]     d;
        logic [15:0]    unit;
        logic           fin;
        logic [1:0]     fin_st;
        logic           no_eot;
        jsu_pkg::t_group g;

        b         = i_item.in_byte;
        d         = jsu_pkg::hex_digit(b);
        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        n_first   = r_first;
        n_second  = r_second;
        fin       = 1'b0;
        fin_st    = jsu_pkg::ST_ERROR;
        no_eot    = 1'b0;
        unit      = '0;
        g.cnt     = 3'd0;
        g.status  = jsu_pkg::ST_DATA;
        g.bytes   = '0;

        if (i_item.start_req) begin
            no_eot = 1'b1;
            if (b != jsu_pkg::CH_QUOTE || i_item.end_of_text) begin
                fin = 1'b1;
            end else begin
                n_mode    = jsu_pkg::MODE_STR;
                n_hex_cnt = 2'd0;
            end
        end else begin
            case (r_mode)
                jsu_pkg::MODE_STR: begin
                    if (b == jsu_pkg::CH_QUOTE) begin
                        fin    = 1'b1;
                        fin_st = jsu_pkg::ST_DONE;
                    end else if (b < jsu_pkg::CH_SPACE) begin
                        fin = 1'b1;
                    end else if (b == jsu_pkg::CH_BSL) begin
                        n_mode = jsu_pkg::MODE_ESC;
                    end else begin
                        g.cnt      = 3'd1;
                        g.bytes[0] = b;
                    end
                end
                jsu_pkg::MODE_ESC: begin
                    n_mode = jsu_pkg::MODE_STR;
                    case (b)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: begin
                            g.cnt      = 3'd1;
                            g.bytes[0] = b;
                        end
                        jsu_pkg::CH_B: begin
                            g.cnt      = 3'd1;
                            g.bytes[0] = 8'h08;
                        end
                        jsu_pkg::CH_F: begin
                            g.cnt      = 3'd1;
                            g.bytes[0] = 8'h0c;
                        end
                        jsu_pkg::CH_N: begin
                            g.cnt      = 3'd1;
                            g.bytes[0] = 8'h0a;
                        end
                        jsu_pkg::CH_R: begin
                            g.cnt      = 3'd1;
                            g.bytes[0] = 8'h0d;
                        end
                        jsu_pkg::CH_T: begin
                            g.cnt      = 3'd1;
                            g.bytes[0] = 8'h09;
                        end
                        jsu_pkg::CH_U: begin
                            n_mode    = jsu_pkg::MODE_HEX1;
                            n_hex_cnt = 2'd0;
                            n_first   = '0;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
                jsu_pkg::MODE_HEX1: begin
                    if (d[4]) begin
                        fin = 1'b1;
                    end else begin
                        unit    = {r_first[11:0], d[3:0]};
                        n_first = unit;
                        if (r_hex_cnt != 2'd3) begin
                            n_hex_cnt = r_hex_cnt + 2'd1;
                        end else begin
                            n_hex_cnt = 2'd0;
                            if (unit >= jsu_pkg::HI_SURR_LO && unit <= jsu_pkg::HI_SURR_HI) begin
                                n_mode = jsu_pkg::MODE_BSL;
                            end else if (unit >= jsu_pkg::LO_SURR_LO &&
                                         unit <= jsu_pkg::LO_SURR_HI) begin
                                fin = 1'b1;
                            end else begin
                                n_mode = jsu_pkg::MODE_STR;
                                g      = jsu_pkg::utf8_encode({5'd0, unit});
                            end
                        end
                    end
                end
                jsu_pkg::MODE_BSL: begin
                    if (b != jsu_pkg::CH_BSL) begin
                        fin = 1'b1;
                    end else begin
                        n_mode = jsu_pkg::MODE_U;
                    end
                end
                jsu_pkg::MODE_U: begin
                    if (b != jsu_pkg::CH_U) begin
                        fin = 1'b1;
                    end else begin
                        n_mode    = jsu_pkg::MODE_HEX2;
                        n_hex_cnt = 2'd0;
                        n_second  = '0;
                    end
                end
                jsu_pkg::MODE_HEX2: begin
                    if (d[4]) begin
                        fin = 1'b1;
                    end else begin
                        unit     = {r_second[11:0], d[3:0]};
                        n_second = unit;
                        if (r_hex_cnt != 2'd3) begin
                            n_hex_cnt = r_hex_cnt + 2'd1;
                        end else begin
                            n_hex_cnt = 2'd0;
                            if (unit < jsu_pkg::LO_SURR_LO || unit > jsu_pkg::LO_SURR_HI) begin
                                fin = 1'b1;
                            end else begin
                                n_mode = jsu_pkg::MODE_STR;
                                g      = jsu_pkg::utf8_encode(jsu_pkg::SUPP_BASE +
                                             {1'b0, r_first[9:0], unit[9:0]});
                            end
                        end
                    end
                end
                default: begin
                    n_mode = jsu_pkg::MODE_IDLE;
                    no_eot = 1'b1;
                end
            endcase
        end

        if (!fin && !no_eot && i_item.end_of_text) begin
            fin = 1'b1;
        end

        if (fin) begin
            n_mode    = jsu_pkg::MODE_IDLE;
            n_hex_cnt = 2'd0;
            g.cnt     = 3'd1;
            g.status  = fin_st;
            g.bytes   = '0;
        end

        o_group = g;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= jsu_pkg::MODE_IDLE;
            r_hex_cnt <= 2'd0;
            r_first   <= '0;
            r_second  <= '0;
        end else if (i_advance) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_first   <= n_first;
            r_second  <= n_second;
        end
    end

endmodule

>>> hdl/jsu_outbuf.sv
// Result register that holds one decoded group and hands it out one transfer at a time.
// Depends on jsu_pkg.
module jsu_outbuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  jsu_pkg::t_group i_group,
    input  logic            i_stall,
    output logic            o_room,
    output logic            o_valid,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_status,
    output logic            o_last
);

    logic [2:0]      r_cnt;
    logic [1:0]      r_status;
    logic [3:0][7:0] r_bytes;
    logic            pop;

    assign o_valid    = (r_cnt != 3'd0);
    assign pop        = o_valid && !i_stall;
    assign o_room     = (r_cnt == 3'd0) || (r_cnt == 3'd1 && !i_stall);
    assign o_out_byte = r_bytes[0];
    assign o_status   = r_status;
    assign o_last     = (r_cnt == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_group.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= i_group.status;
            r_bytes  <= i_group.bytes;
        end else if (pop) begin
            r_bytes <= {8'h00, r_bytes[3:1]};
        end
    end

endmodule

>>> hdl/json_string_unescape_utf8.sv
// Streaming JSON string unescaper with UTF-8 output; top level over jsu_decode and jsu_outbuf.
// A byte waits in the input register and its first result is offered from the output register.
// Throughput: one input byte per cycle while each byte gives at most one result and i_stall
// is low; a byte with more results (up to four) holds the input until its last is handed out.
// Reset (synchronous, active low) empties both registers and leaves the scanner idle.
module json_string_unescape_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_start_req,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_last
);

    logic            r_in_valid;
    jsu_pkg::t_item  r_item;
    jsu_pkg::t_group group;
    logic            room;
    logic            advance;
    logic            accept;

    assign advance = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= '{in_byte: i_in_byte, start_req: i_start_req, end_of_text: i_end_of_text};
        end
    end

    jsu_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .o_group   (group)
    );

    jsu_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_group    (group),
        .i_stall    (i_stall),
        .o_room     (room),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule
